FILE: hw/rtl/bilinear_texel_sampler_unit_assert.svh
// Assertion macros for the bilinear texel sampler RTL.
// Needs signals named clk and rst in the scope where a macro is used.
`ifndef BILINEAR_TEXEL_SAMPLER_UNIT_ASSERT_SVH
`define BILINEAR_TEXEL_SAMPLER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define BTS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define BTS_ASSERT_IMPL(lbl, ante, cons, msg)
`define BTS_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

FILE: hw/rtl/bts_pkg.sv
// Shared constants, types and lerp functions for the bilinear texel sampler.
// No dependencies; imported by every module of the block.
package bts_pkg;

  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;
  localparam int FRAC_BITS  = 8;

  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int ROW_W     = $clog2(MAX_HEIGHT);
  localparam int AXIS_W    = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int COORD_W   = 16;
  localparam int DIM_W     = 7;
  localparam int CFG_IDX_W = 1;
  localparam int CHAN_W    = 8;
  localparam int NUM_CHAN  = 3;
  localparam int PIX_W     = CHAN_W * NUM_CHAN;
  localparam int HALF_PIX  = 1 << (FRAC_BITS - 1);

  // four banks split by row and column parity
  localparam int NUM_BANKS  = 4;
  localparam int BANK_SEL_W = 2;
  localparam int BANK_AW    = (COL_W - 1) + (ROW_W - 1);
  localparam int BANK_DEPTH = 1 << BANK_AW;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SAMPLE = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef logic [PIX_W-1:0]     pixel_t;
  typedef logic [FRAC_BITS-1:0] frac_t;

  typedef struct packed {
    logic             in_image;
    logic [COL_W-1:0] x0;
    logic [COL_W-1:0] x1;
    logic [ROW_W-1:0] y0;
    logic [ROW_W-1:0] y1;
    frac_t            fx;
    frac_t            fy;
  } sample_req_t;

  // a + floor((b - a) * w / 2^FRAC_BITS), wraps to 8 bits
  function automatic logic [CHAN_W-1:0] lerp8(input logic [CHAN_W-1:0] a,
                                              input logic [CHAN_W-1:0] b,
                                              input frac_t w);
    logic signed [CHAN_W:0]             diff;
    logic signed [CHAN_W+FRAC_BITS+1:0] prod;
    logic signed [CHAN_W+FRAC_BITS+1:0] q;
    diff = signed'({1'b0, b}) - signed'({1'b0, a});
    prod = diff * signed'({1'b0, w});
    q    = prod >>> FRAC_BITS;
    return a + q[CHAN_W-1:0];
  endfunction

  function automatic pixel_t lerp_color(input pixel_t a, input pixel_t b, input frac_t w);
    pixel_t r;
    for (int i = 0; i < NUM_CHAN; i++) begin
      r[i*CHAN_W +: CHAN_W] = lerp8(a[i*CHAN_W +: CHAN_W], b[i*CHAN_W +: CHAN_W], w);
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/bilinear_texel_sampler_unit.sv
// Bilinear texel sampler: top level with an RGB888 pixel store.
// Depends on bts_pkg, bts_addr, bts_store, bts_filter and the assert header.
//
// Usage:
//   Input words are taken at a rising edge with start high and busy low.
//   op = OP_WRITE stores pixel_value at (pixel_column, pixel_row); it gives
//   no result. op = OP_SAMPLE filters the image at (sample_x, sample_y),
//   signed fixed point with FRAC_BITS fraction bits.
//   Each sample word gives exactly one result word: the bank read is
//   registered, then the vertical lerps, then the horizontal lerp. A
//   position outside image_width x image_height gives zero.
//   Throughput: one word per cycle, writes and samples mixed freely. The
//   four neighbors come from four banks split by row/column parity, so a
//   single read port per bank serves a whole sample in one cycle.
//   A write lands in its bank at the accepting edge, so a sample taken on
//   the very next cycle already sees it; no forwarding is needed.
//   The receiver cannot stall; done is a plain one-cycle strobe.
//   Reset clears the pipeline and sets both size registers to 64; busy is
//   high with rst and in the cycle after it falls. The store itself is
//   not cleared: only pixels that were written may be sampled.
//   Size registers are written through cfg_wr_en/cfg_index/cfg_data and
//   must change only while no sample is in flight.
`include "bilinear_texel_sampler_unit_assert.svh"

module bilinear_texel_sampler_unit
  import bts_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic                      op,
  input  logic [COL_W-1:0]          pixel_column,
  input  logic [ROW_W-1:0]          pixel_row,
  input  logic [PIX_W-1:0]          pixel_value,
  input  logic signed [COORD_W-1:0] sample_x,
  input  logic signed [COORD_W-1:0] sample_y,
  output logic                      done,
  output logic [PIX_W-1:0]          sampled_color,
  input  logic                      cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [DIM_W-1:0]          cfg_data
);

  logic [DIM_W-1:0] image_width;
  logic [DIM_W-1:0] image_height;
  logic [DIM_W-1:0] w_eff;
  logic [DIM_W-1:0] h_eff;

  logic accept;
  logic sample_acc;
  logic write_acc;

  sample_req_t                     req;
  sample_req_t                     s1_req;
  logic                            s1_valid;
  logic [NUM_BANKS-1:0][BANK_AW-1:0] rd_addr;
  pixel_t [NUM_BANKS-1:0]          texels;

  assign accept     = start && !busy;
  assign sample_acc = accept && (op == OP_SAMPLE);
  assign write_acc  = accept && (op == OP_WRITE);

  // sizes beyond the store act as the store size
  assign w_eff = (image_width  > DIM_W'(MAX_WIDTH))  ? DIM_W'(MAX_WIDTH)  : image_width;
  assign h_eff = (image_height > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : image_height;

  // config registers and control
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= DIM_W'(64);
      image_height <= DIM_W'(64);
      busy         <= 1'b1;
      s1_valid     <= 1'b0;
    end else begin
      busy     <= 1'b0;
      s1_valid <= sample_acc;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_IMAGE_WIDTH:  image_width  <= cfg_data;
          CFG_IMAGE_HEIGHT: image_height <= cfg_data;
        endcase
      end
    end
  end

  // sample word travels alongside the bank read
  always_ff @(posedge clk) begin
    if (sample_acc) begin
      s1_req <= req;
    end
  end

  bts_addr u_addr (
    .sample_x (sample_x),
    .sample_y (sample_y),
    .w_eff    (w_eff),
    .h_eff    (h_eff),
    .req      (req),
    .rd_addr  (rd_addr)
  );

  bts_store u_store (
    .clk     (clk),
    .wr_en   (write_acc),
    .wr_col  (pixel_column),
    .wr_row  (pixel_row),
    .wr_data (pixel_value),
    .rd_en   (sample_acc),
    .rd_addr (rd_addr),
    .rd_data (texels)
  );

  bts_filter u_filter (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .in_req    (s1_req),
    .texels    (texels),
    .out_valid (done),
    .out_color (sampled_color)
  );

  `BTS_ASSERT_IMPL(a_done_has_sample, done, $past(sample_acc, 3), "result word without a sample")
  `BTS_ASSERT_IMPL(a_sample_gives_done,
    $past(sample_acc, 3) && !$past(rst, 1) && !$past(rst, 2) && !$past(rst, 3),
    done, "sample word gave no result")
  `BTS_ASSERT_IMPL(a_neighbor_in_image, req.in_image,
    (DIM_W'(req.x1) < w_eff) && (DIM_W'(req.y1) < h_eff), "neighbor outside image")
  `BTS_ASSERT_NEXT(a_write_no_stage, write_acc, !s1_valid, "write word entered filter")

endmodule

FILE: hw/rtl/bts_addr.sv
// Sample position to neighbor coordinates, weights and per-bank read addresses.
// Depends on bts_pkg.
module bts_addr
  import bts_pkg::*;
(
  input  logic signed [COORD_W-1:0]       sample_x,
  input  logic signed [COORD_W-1:0]       sample_y,
  input  logic [DIM_W-1:0]                w_eff,
  input  logic [DIM_W-1:0]                h_eff,
  output sample_req_t                     req,
  output logic [NUM_BANKS-1:0][BANK_AW-1:0] rd_addr
);

  // p - half pixel, clamped to [0, (size-1) << FRAC_BITS]
  function automatic logic [AXIS_W+FRAC_BITS-1:0] center_of(
      input logic signed [COORD_W-1:0] p, input logic [DIM_W-1:0] size);
    logic signed [COORD_W:0] c;
    logic signed [COORD_W:0] top;
    c   = {p[COORD_W-1], p} - (COORD_W+1)'(HALF_PIX);
    top = (COORD_W+1)'({size - DIM_W'(1), {FRAC_BITS{1'b0}}});
    if (c < 0) begin
      c = '0;
    end else if (c > top) begin
      c = top;
    end
    return c[AXIS_W+FRAC_BITS-1:0];
  endfunction

  logic [AXIS_W+FRAC_BITS-1:0] cx;
  logic [AXIS_W+FRAC_BITS-1:0] cy;
  logic [COL_W-1:0]            x0;
  logic [ROW_W-1:0]            y0;
  logic [DIM_W-1:0]            x0_inc;
  logic [DIM_W-1:0]            y0_inc;
  logic                        in_x;
  logic                        in_y;

  assign in_x = !sample_x[COORD_W-1] &&
                (COORD_W'(sample_x) < COORD_W'({w_eff, {FRAC_BITS{1'b0}}}));
  assign in_y = !sample_y[COORD_W-1] &&
                (COORD_W'(sample_y) < COORD_W'({h_eff, {FRAC_BITS{1'b0}}}));

  assign cx     = center_of(sample_x, w_eff);
  assign cy     = center_of(sample_y, h_eff);
  assign x0     = cx[FRAC_BITS +: COL_W];
  assign y0     = cy[FRAC_BITS +: ROW_W];
  assign x0_inc = DIM_W'(x0) + DIM_W'(1);
  assign y0_inc = DIM_W'(y0) + DIM_W'(1);

  always_comb begin
    req.in_image = in_x && in_y;
    req.x0       = x0;
    req.y0       = y0;
    req.x1       = (x0_inc < w_eff) ? x0_inc[COL_W-1:0] : x0;
    req.y1       = (y0_inc < h_eff) ? y0_inc[ROW_W-1:0] : y0;
    req.fx       = cx[FRAC_BITS-1:0];
    req.fy       = cy[FRAC_BITS-1:0];
  end

  // bank index = {row parity, column parity}; each bank reads the neighbor
  // of its parity, or anything when no neighbor has it (edge reuse)
  always_comb begin
    logic [COL_W-1:0] col_sel;
    logic [ROW_W-1:0] row_sel;
    for (int b = 0; b < NUM_BANKS; b++) begin
      col_sel    = (req.x0[0] == b[0]) ? req.x0 : req.x1;
      row_sel    = (req.y0[0] == b[1]) ? req.y0 : req.y1;
      rd_addr[b] = {row_sel[ROW_W-1:1], col_sel[COL_W-1:1]};
    end
  end

endmodule

FILE: hw/rtl/bts_store.sv
// Pixel store: four parity banks, one write and one registered read per bank.
// Depends on bts_pkg.
module bts_store
  import bts_pkg::*;
(
  input  logic                              clk,
  input  logic                              wr_en,
  input  logic [COL_W-1:0]                  wr_col,
  input  logic [ROW_W-1:0]                  wr_row,
  input  pixel_t                            wr_data,
  input  logic                              rd_en,
  input  logic [NUM_BANKS-1:0][BANK_AW-1:0] rd_addr,
  output pixel_t [NUM_BANKS-1:0]            rd_data
);

  logic [BANK_AW-1:0]    wr_addr;
  logic [BANK_SEL_W-1:0] wr_bank;

  assign wr_addr = {wr_row[ROW_W-1:1], wr_col[COL_W-1:1]};
  assign wr_bank = {wr_row[0], wr_col[0]};

  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    pixel_t mem [BANK_DEPTH];
    pixel_t q;
    logic   we;

    assign we = wr_en && (wr_bank == BANK_SEL_W'(b));

    always_ff @(posedge clk) begin
      if (we) begin
        mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
        q <= mem[rd_addr[b]];
      end
    end

    assign rd_data[b] = q;
  end

endmodule

FILE: hw/rtl/bts_filter.sv
// Two-stage bilinear filter: vertical lerps, then horizontal lerp and output.
// Depends on bts_pkg.
module bts_filter
  import bts_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  sample_req_t            in_req,
  input  pixel_t [NUM_BANKS-1:0] texels,
  output logic                   out_valid,
  output pixel_t                 out_color
);

  pixel_t t00, t01, t10, t11;
  pixel_t left_q, right_q;
  frac_t  fx_q;
  logic   inside_q;
  logic   mid_valid;

  // txy: x0/x1 column, y0/y1 row
  assign t00 = texels[{in_req.y0[0], in_req.x0[0]}];
  assign t01 = texels[{in_req.y1[0], in_req.x0[0]}];
  assign t10 = texels[{in_req.y0[0], in_req.x1[0]}];
  assign t11 = texels[{in_req.y1[0], in_req.x1[0]}];

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      mid_valid <= in_valid;
      out_valid <= mid_valid;
    end
    left_q    <= lerp_color(t00, t01, in_req.fy);
    right_q   <= lerp_color(t10, t11, in_req.fy);
    fx_q      <= in_req.fx;
    inside_q  <= in_req.in_image;
    out_color <= inside_q ? lerp_color(left_q, right_q, fx_q) : '0;
  end

endmodule
